// ===== hw/rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES   = 4096;
   localparam int HEADER_BYTES = 8;

   localparam int OFS_W  = $clog2(HEAP_BYTES);
   localparam int TOP_W  = $clog2(HEAP_BYTES + 1);
   localparam int SIZE_W = 13;
   localparam int SUM_W  = ((TOP_W > SIZE_W) ? TOP_W : SIZE_W) + 1;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [11:0] num_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] payload_address;
      logic        fail;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [OFS_W-1:0] addr;
   } hdr_rd_type;

   typedef struct packed {
      logic              flag_we;
      logic              size_we;
      logic [OFS_W-1:0]  addr;
      logic              flag;
      logic [SIZE_W-1:0] size;
   } hdr_wr_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ffha_hdr_store.sv =====
`default_nettype none
module ffha_hdr_store (
   input  wire logic                       clock,
   input  wire ffha_pkg::hdr_rd_type       rd,
   input  wire ffha_pkg::hdr_wr_type       wr,
   output logic                            rd_flag,
   output logic [ffha_pkg::SIZE_W-1:0]     rd_size
);
   import ffha_pkg::*;

   logic              flag_mem [HEAP_BYTES];
   logic [SIZE_W-1:0] size_mem [HEAP_BYTES];

   logic              rd_flag_ff;
   logic [SIZE_W-1:0] rd_size_ff;

   always_ff @(posedge clock) begin
      if (wr.flag_we) begin
         flag_mem[wr.addr] <= wr.flag;
      end
      if (wr.size_we) begin
         size_mem[wr.addr] <= wr.size;
      end
      if (rd.en) begin
         rd_flag_ff <= flag_mem[rd.addr];
         rd_size_ff <= size_mem[rd.addr];
      end
   end

   assign rd_flag = rd_flag_ff;
   assign rd_size = rd_size_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ffha_ctrl.sv =====
`default_nettype none
module ffha_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire ffha_pkg::req_type          req_payload,
   input  wire logic [31:0]                heap_base,
   output logic                            done_valid,
   input  wire logic                       done_ready,
   output ffha_pkg::rsp_type               done_payload,
   output ffha_pkg::hdr_rd_type            hdr_rd,
   output ffha_pkg::hdr_wr_type            hdr_wr,
   input  wire logic                       hdr_flag,
   input  wire logic [ffha_pkg::SIZE_W-1:0] hdr_size
);
   import ffha_pkg::*;

   state_type         state_ff, state_in;
   logic [TOP_W-1:0]  loc_ff, loc_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   rsp_type           res_ff, res_in;

   logic [31:0]       free_ofs;
   logic [SUM_W-1:0]  next_loc;
   logic [SUM_W-1:0]  append_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
      loc_ff  <= loc_in;
      need_ff <= need_in;
      res_ff  <= res_in;
   end

   assign free_ofs   = req_payload.free_address - heap_base - 32'(HEADER_BYTES);
   assign next_loc   = SUM_W'(loc_ff) + SUM_W'(hdr_size);
   assign append_end = SUM_W'(top_ff) + SUM_W'(need_ff);

   always_comb begin
      state_in   = state_ff;
      loc_in     = loc_ff;
      top_in     = top_ff;
      need_in    = need_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;
      hdr_rd     = '0;
      hdr_wr     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in = '0;
               if (req_payload.cmd == CMD_FREE) begin
                  if (free_ofs < 32'(HEAP_BYTES)) begin
                     hdr_wr.flag_we = 1'b1;
                     hdr_wr.addr    = free_ofs[OFS_W-1:0];
                     hdr_wr.flag    = 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  need_in = SIZE_W'(req_payload.num_bytes) + SIZE_W'(HEADER_BYTES);
                  loc_in  = '0;
                  if (top_ff != '0) begin
                     hdr_rd.en   = 1'b1;
                     hdr_rd.addr = '0;
                     state_in    = ST_WALK;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
            end
         end
         ST_WALK: begin
            if (hdr_flag && (hdr_size >= need_ff)) begin
               hdr_wr.flag_we         = 1'b1;
               hdr_wr.addr            = loc_ff[OFS_W-1:0];
               hdr_wr.flag            = 1'b0;
               res_in.payload_address = heap_base + 32'(loc_ff) + 32'(HEADER_BYTES);
               state_in               = ST_DONE;
            end else if (hdr_size == '0) begin
               state_in = ST_APPEND;
            end else if (next_loc < SUM_W'(top_ff)) begin
               hdr_rd.en   = 1'b1;
               hdr_rd.addr = next_loc[OFS_W-1:0];
               loc_in      = next_loc[TOP_W-1:0];
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (append_end > SUM_W'(HEAP_BYTES)) begin
               res_in.fail = 1'b1;
            end else begin
               hdr_wr.flag_we         = 1'b1;
               hdr_wr.size_we         = 1'b1;
               hdr_wr.addr            = top_ff[OFS_W-1:0];
               hdr_wr.flag            = 1'b0;
               hdr_wr.size            = need_ff;
               top_in                 = append_end[TOP_W-1:0];
               res_in.payload_address = heap_base + 32'(top_ff) + 32'(HEADER_BYTES);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign done_payload = res_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// Channel    Direction  Handshake              Payload
// request    in         req_valid / req_ready  req_payload (cmd, num_bytes, free_address)
// response   out        rsp_valid / rsp_ready  rsp_payload (payload_address, fail)
// csr        in         csr_write_enable       csr_write_data (heap_base)
// A free request goes from acceptance through ST_DONE to the response register; an allocate
// request walks the headers in ST_WALK, reading one header per cycle from the header memory, and
// goes to ST_DONE when it takes a free block, or through ST_APPEND first when it appends or fails.
// Reset clears heap_top, heap_base and the control state; the header memory is not cleared.
// A new request is accepted while the previous response waits; a stalled response holds
// the finished request in the controller until the response register frees up.
`default_nettype none
module first_fit_heap_allocator_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffha_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffha_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [31:0]       csr_write_data
);
   import ffha_pkg::*;

   logic [31:0]       heap_base_ff, heap_base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              done_valid;
   logic              done_ready;
   rsp_type           done_payload;
   hdr_rd_type        hdr_rd;
   hdr_wr_type        hdr_wr;
   logic              hdr_flag;
   logic [SIZE_W-1:0] hdr_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         heap_base_ff <= heap_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      heap_base_in = csr_write_enable ? csr_write_data : heap_base_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done_ready) begin
         rsp_valid_in = done_valid;
         rsp_in       = done_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   ffha_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .heap_base    (heap_base_ff),
      .done_valid   (done_valid),
      .done_ready   (done_ready),
      .done_payload (done_payload),
      .hdr_rd       (hdr_rd),
      .hdr_wr       (hdr_wr),
      .hdr_flag     (hdr_flag),
      .hdr_size     (hdr_size)
   );

   ffha_hdr_store u_hdr_store (
      .clock   (clock),
      .rd      (hdr_rd),
      .wr      (hdr_wr),
      .rd_flag (hdr_flag),
      .rd_size (hdr_size)
   );

endmodule
`default_nettype wire

// ===== test/tb_first_fit_heap_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator_core;
   import ffha_pkg::*;

   localparam int STALL_LIMIT = 10000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   first_fit_heap_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic              hdr_avail [HEAP_BYTES];
   logic [SIZE_W-1:0] hdr_total [HEAP_BYTES];
   int unsigned       heap_top;
   logic [31:0]       base_addr;

   rsp_type     expected_rsp [$];
   int unsigned live_offsets [$];
   int unsigned last_freed;
   bit          heap_filled;
   bit          quiet_mode;
   int          rsp_hold_left;

   int unsigned request_count;
   int unsigned alloc_count;
   int unsigned refused_count;
   int unsigned free_count;
   int unsigned longest_walk;
   int unsigned base_settings;
   int unsigned response_count;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   rsp_type     due;

   always #5 clock = ~clock;

   function automatic rsp_type predict_heap_op(input req_type r);
      rsp_type     res;
      logic [31:0] ofs;
      int unsigned need;
      int unsigned loc;
      int unsigned visited;
      bit          found;
      bit          stop;
      res = '0;
      if (r.cmd == CMD_FREE) begin
         free_count++;
         ofs = r.free_address - base_addr - 32'(HEADER_BYTES);
         if (ofs < 32'(HEAP_BYTES)) hdr_avail[ofs] = 1'b1;
         return res;
      end
      alloc_count++;
      need = 32'(r.num_bytes) + HEADER_BYTES;
      loc = 0;
      visited = 0;
      found = 0;
      stop = 0;
      while (loc < heap_top && loc < HEAP_BYTES && !found && !stop) begin
         visited++;
         if (hdr_avail[loc] && hdr_total[loc] >= need) begin
            hdr_avail[loc] = 1'b0;
            found = 1;
         end else if (hdr_total[loc] == 0) begin
            stop = 1;
         end else begin
            loc += hdr_total[loc];
         end
      end
      if (visited > longest_walk) longest_walk = visited;
      if (!found) begin
         if (heap_top + need > HEAP_BYTES) begin
            refused_count++;
            res.fail = 1'b1;
            return res;
         end
         loc = heap_top;
         hdr_avail[loc] = 1'b0;
         hdr_total[loc] = need[SIZE_W-1:0];
         heap_top += need;
      end
      live_offsets.push_back(loc);
      res.payload_address = base_addr + 32'(loc) + 32'(HEADER_BYTES);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %h, got %h (response %0d)", what, want, got,
               response_count);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input cmd_type c, input logic [11:0] n,
                               input logic [31:0] a);
      req_type r;
      r.cmd = c;
      r.num_bytes = n;
      r.free_address = a;
      while (!quiet_mode && $urandom_range(0, 99) < 24) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(predict_heap_op(r));
      request_count++;
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic set_heap_base(input logic [31:0] v);
      wait_for_responses();
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      base_addr = v;
      base_settings++;
   endtask

   task automatic test_directed_sequence();
      send_request(CMD_ALLOC, 12'd0, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 12'd4088, 32'h0);
      send_request(CMD_ALLOC, 12'd1, 32'h0);
      send_request(CMD_ALLOC, 12'd23, 32'h0);
      send_request(CMD_FREE, 12'd4088, base_addr + 32'd8);
      send_request(CMD_FREE, 12'd0, base_addr + 32'd8);
      send_request(CMD_ALLOC, 12'd0, 32'h0);
      send_request(CMD_FREE, 12'd0, base_addr + 32'd25);
      send_request(CMD_ALLOC, 12'd30, 32'h0);
      send_request(CMD_ALLOC, 12'd20, 32'h0);
      send_request(CMD_FREE, 12'd0, base_addr);
      send_request(CMD_FREE, 12'd0, base_addr + 32'(HEADER_BYTES + HEAP_BYTES));
      send_request(CMD_FREE, 12'd0, 32'hFFFF_FFFF);
      send_request(CMD_FREE, 12'd0, base_addr + 32'd20);
      send_request(CMD_FREE, 12'd0, base_addr + 32'd3008);
      send_request(CMD_FREE, 12'd0, base_addr + 32'(HEADER_BYTES + HEAP_BYTES - 1));
      send_request(CMD_ALLOC, 12'd4087, 32'h0);
      send_request(CMD_ALLOC, 12'd0, 32'h0);
      send_request(CMD_FREE, 12'd0, base_addr + 32'd8);
      send_request(CMD_ALLOC, 12'd7, 32'h0);
   endtask

   // Walks the heap right up to its last byte, then asks for one block more.
   task automatic test_exact_fill();
      int unsigned room;
      int unsigned loc;
      bit          fits;
      room = HEAP_BYTES - heap_top;
      fits = (room >= HEADER_BYTES);
      while (fits) begin
         fits = 0;
         loc = 0;
         while (loc < heap_top && !fits) begin
            if (hdr_avail[loc] && hdr_total[loc] >= room) fits = 1;
            else loc += hdr_total[loc];
         end
         if (fits) send_request(CMD_ALLOC, 12'(room - HEADER_BYTES), $urandom);
      end
      if (room >= HEADER_BYTES) send_request(CMD_ALLOC, 12'(room - HEADER_BYTES), $urandom);
      send_request(CMD_ALLOC, 12'd0, $urandom);
      heap_filled = 1;
   endtask

   task automatic send_random_request();
      int unsigned pick;
      int unsigned idx;
      int unsigned ofs;
      int unsigned lo;
      logic [11:0] n;
      logic [31:0] a;
      if (!heap_filled && HEAP_BYTES - heap_top <= 64) test_exact_fill();
      pick = $urandom_range(0, 99);
      if (pick >= 55 && pick < 85 && live_offsets.size() == 0) pick = 0;
      if (pick < 55) begin
         if ($urandom_range(0, 9) != 0) begin
            n = 12'($urandom_range(0, 40));
         end else if (!heap_filled) begin
            lo = HEAP_BYTES - heap_top;
            if (lo > 4088) lo = 4088;
            n = 12'($urandom_range(lo, 4088));
         end else begin
            n = 12'($urandom_range(0, 4088));
         end
         send_request(CMD_ALLOC, n, $urandom);
      end else if (pick < 85) begin
         idx = $urandom_range(0, live_offsets.size() - 1);
         ofs = live_offsets[idx];
         live_offsets.delete(idx);
         last_freed = ofs;
         send_request(CMD_FREE, 12'($urandom_range(0, 4088)),
                      base_addr + 32'(ofs + HEADER_BYTES));
      end else if (pick < 90) begin
         send_request(CMD_FREE, 12'($urandom_range(0, 4088)),
                      base_addr + 32'(last_freed + HEADER_BYTES));
      end else if (pick < 95) begin
         if (live_offsets.size() != 0) begin
            ofs = live_offsets[$urandom_range(0, live_offsets.size() - 1)] +
                  $urandom_range(1, 7);
         end else begin
            ofs = $urandom_range(0, HEAP_BYTES - 1);
         end
         send_request(CMD_FREE, 12'd0, base_addr + 32'(ofs + HEADER_BYTES));
      end else begin
         case ($urandom_range(0, 2))
            0: a = $urandom;
            1: a = base_addr + 32'(HEADER_BYTES + HEAP_BYTES) + 32'($urandom_range(0, 1000));
            default: a = base_addr + 32'($urandom_range(0, HEADER_BYTES - 1));
         endcase
         send_request(CMD_FREE, 12'($urandom_range(0, 4088)), a);
      end
   endtask

   task automatic test_random_traffic(input logic [31:0] new_base, input int count,
                                      input bit no_gaps);
      set_heap_base(new_base);
      quiet_mode = no_gaps;
      repeat (count) begin
         if ($urandom_range(0, 99) < 2) wait_for_responses();
         send_random_request();
      end
      quiet_mode = 0;
   endtask

   // The response side holds off while requests keep coming, so the block backs up.
   task automatic test_response_backpressure();
      quiet_mode = 1;
      rsp_hold_left = 200;
      repeat (12) send_random_request();
      quiet_mode = 0;
      wait_for_responses();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready = quiet_mode || ($urandom_range(0, 99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with nothing pending", 32'h0,
                            rsp_payload.payload_address);
         end else begin
            due = expected_rsp.pop_front();
            if (rsp_payload.payload_address !== due.payload_address)
               report_mismatch("payload_address", due.payload_address,
                               rsp_payload.payload_address);
            if (rsp_payload.fail !== due.fail)
               report_mismatch("fail", 32'(due.fail), 32'(rsp_payload.fail));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 32'h0;
      for (int i = 0; i < HEAP_BYTES; i++) begin
         hdr_avail[i] = 1'b0;
         hdr_total[i] = '0;
      end
      heap_top = 0;
      base_addr = 32'h0;
      last_freed = 0;
      heap_filled = 0;
      quiet_mode = 0;
      rsp_hold_left = 0;
      request_count = 0;
      alloc_count = 0;
      refused_count = 0;
      free_count = 0;
      longest_walk = 0;
      base_settings = 0;
      response_count = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_sequence();
      test_random_traffic(32'hFFFF_FFFF, 250, 0);
      test_response_backpressure();
      test_random_traffic($urandom, 250, 0);
      test_random_traffic(32'h0000_0000, 250, 1);
      test_random_traffic(32'hFFFF_F000, 250, 0);

      wait_for_responses();
      repeat (50) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("responses never delivered", 32'h0, 32'(expected_rsp.size()));

      $display("Sent %0d requests: %0d allocations (%0d refused for lack of room), %0d frees.",
               request_count, alloc_count, refused_count, free_count);
      $display("Heap top reached %0d of %0d bytes; longest header walk %0d; %0d base values.",
               heap_top, HEAP_BYTES, longest_walk, base_settings);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_hdr_store.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_core.sv
test/tb_first_fit_heap_allocator_core.sv
